@@ rtl/rcwc_pkg.sv @@
// ---------------------------------------------------------------------------
// Ray-cast wall column package
// Shared constants for the ray caster and its sine series unit.
// ---------------------------------------------------------------------------
`default_nettype none
package rcwc_pkg;
    localparam int SCREEN_WIDTH  = 1280;
    localparam int SCREEN_HEIGHT = 720;
    localparam int CELL_SIZE     = 64;
    localparam int MAP_COLS      = 32;
    localparam int MAP_ROWS      = 16;
    localparam int MAX_STEPS     = 2048;
    localparam int STORE_ROWS    = 16;
    localparam int STORE_COLS    = 32;
    localparam int FRAC_BITS     = 14;
    localparam int CELL_SHIFT    = FRAC_BITS + $clog2(CELL_SIZE);
    localparam int POS_W         = 34;
    localparam int STEP_W        = $clog2(MAX_STEPS + 1);
    localparam int HEIGHT_NUM    = CELL_SIZE * (SCREEN_WIDTH / 2);
    localparam int NUM_W         = $clog2(HEIGHT_NUM + 1);
    localparam int ROW_AW        = $clog2(STORE_ROWS);

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    // Pi in Q30 and the Taylor divisors 6, 20, 42, 72, 110 and 156 as
    // reciprocals, exact for dividends below 2**32.
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam int          TAYLOR_TERMS = 6;
    localparam int          DIV_SHIFT [6] = '{35, 37, 38, 39, 39, 40};
    localparam logic [32:0] DIV_MAGIC [6] = '{
        33'(((64'd1 << 35) + 64'd5) / 64'd6),
        33'(((64'd1 << 37) + 64'd19) / 64'd20),
        33'(((64'd1 << 38) + 64'd41) / 64'd42),
        33'(((64'd1 << 39) + 64'd71) / 64'd72),
        33'(((64'd1 << 39) + 64'd109) / 64'd110),
        33'(((64'd1 << 40) + 64'd155) / 64'd156)
    };

    typedef logic signed [15:0] t_trig;
endpackage
`default_nettype wire

@@ rtl/rcwc_ram.sv @@
// ---------------------------------------------------------------------------
// Ray-cast generic RAM
// Single write port, single read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none
module rcwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/raycast_wall_column.sv @@
// ---------------------------------------------------------------------------
// Ray-cast wall column
// Marches a ray over a stored wall map and produces the wall span of a column.
// ---------------------------------------------------------------------------
// A map write is stored as it is accepted. A cast forms both direction components with a
// Taylor series, marches with a map read and a test per cell, divides for the wall
// height bit by bit and then forms the span; a miss or a zero-step hit skips the
// divider. One transaction is in work at a time and the next is accepted in the cycle
// after the result is taken. Reset clears the map one row a cycle.
`default_nettype none
module raycast_wall_column (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic [3:0]  i_row_index,
    input  wire logic [31:0] i_row_bits,
    input  wire logic [18:0] i_player_x,
    input  wire logic [17:0] i_player_y,
    input  wire logic [11:0] i_ray_angle,
    input  wire logic [10:0] i_column,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [10:0]      o_out_column,
    output logic [9:0]       o_span_start,
    output logic [9:0]       o_span_end,
    output logic [11:0]      o_step_count,
    output logic             o_hit
);
    localparam int PW = rcwc_pkg::POS_W;
    localparam int SW = rcwc_pkg::STEP_W;
    localparam int NW = rcwc_pkg::NUM_W;
    localparam int AW = rcwc_pkg::ROW_AW;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_TEST  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_SPAN  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;
    localparam logic [2:0] ST_SINE  = 3'd7;

    localparam logic [2:0] SN_X   = 3'd0;
    localparam logic [2:0] SN_X2  = 3'd1;
    localparam logic [2:0] SN_MUL = 3'd2;
    localparam logic [2:0] SN_DIV = 3'd3;
    localparam logic [2:0] SN_FIN = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [AW:0]            r_clr;
    logic signed [PW-1:0]   r_px, r_py;
    logic signed [15:0]     r_dx, r_dy;
    logic [SW-1:0]          r_steps;
    logic [10:0]            r_column;
    logic                   r_hit;
    logic [NW-1:0]          r_quot;
    logic [NW-1:0]          r_rem;
    logic [$clog2(NW+1)-1:0] r_bit;
    logic [9:0]             r_start, r_end;

    logic [11:0]            r_angle;
    logic                   r_axis;
    logic [2:0]             r_sn;
    logic [2:0]             r_iter;
    logic [31:0]            r_x, r_x2, r_term, r_part;
    logic signed [33:0]     r_sum;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [31:0]            ram_wdata, ram_rdata;

    logic                   accept;
    logic                   outside;
    logic [PW-1:0]          cx_full, cy_full;
    logic                   wall;
    logic [NW:0]            rem_sh;

    logic [11:0]            sin_a;
    logic [10:0]            sin_k;
    logic [42:0]            x_prod;
    logic [63:0]            sq_prod, tx_prod;
    logic [64:0]            div_prod;
    logic [31:0]            div_q;
    logic [33:0]            sum_pos, sum_rnd;
    logic [14:0]            sin_mag;
    rcwc_pkg::t_trig        sin_v;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE);

    assign cx_full = PW'($unsigned(r_px) >> rcwc_pkg::CELL_SHIFT);
    assign cy_full = PW'($unsigned(r_py) >> rcwc_pkg::CELL_SHIFT);
    assign outside = r_px[PW-1] || r_py[PW-1]
        || cx_full >= PW'(rcwc_pkg::MAP_COLS) || cx_full >= PW'(rcwc_pkg::STORE_COLS)
        || cy_full >= PW'(rcwc_pkg::MAP_ROWS) || cy_full >= PW'(rcwc_pkg::STORE_ROWS);
    assign ram_raddr = cy_full[AW-1:0];
    assign wall = outside || ram_rdata[cx_full[$clog2(rcwc_pkg::STORE_COLS)-1:0]];

    assign ram_we = (r_state == ST_CLEAR) || (accept && i_action == rcwc_pkg::ACT_WRITE);
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr[AW-1:0] : i_row_index;
    assign ram_wdata = (r_state == ST_CLEAR) ? 32'd0 : i_row_bits;

    rcwc_ram #(.WIDTH(32), .DEPTH(rcwc_pkg::STORE_ROWS)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rem_sh = {r_rem, r_quot[NW-1]};

    assign sin_a    = r_axis ? r_angle + 12'd1024 : r_angle;
    assign sin_k    = sin_a[10] ? 11'd1024 - {1'b0, sin_a[9:0]} : {1'b0, sin_a[9:0]};
    assign x_prod   = 43'(sin_k) * 43'(rcwc_pkg::PI_Q30);
    assign sq_prod  = 64'(r_x) * 64'(r_x);
    assign tx_prod  = 64'(r_term) * 64'(r_x2);
    assign div_prod = 65'(r_part) * 65'(rcwc_pkg::DIV_MAGIC[r_iter]);
    assign div_q    = 32'(div_prod >> rcwc_pkg::DIV_SHIFT[r_iter]);
    assign sum_pos  = r_sum[33] ? 34'd0 : $unsigned(r_sum);
    assign sum_rnd  = sum_pos + 34'd32768;
    assign sin_mag  = (sum_rnd[33:16] > 18'd16384) ? 15'd16384 : sum_rnd[30:16];
    assign sin_v    = sin_a[11] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == (AW+1)'(rcwc_pkg::STORE_ROWS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (accept && i_action == rcwc_pkg::ACT_CAST) n_state = ST_SINE;
            ST_SINE:  if (r_sn == SN_FIN && r_axis) n_state = ST_READ;
            ST_READ:  n_state = ST_TEST;
            ST_TEST: begin
                if (wall) n_state = (r_steps == '0) ? ST_SPAN : ST_DIV;
                else if (r_steps >= SW'(rcwc_pkg::MAX_STEPS)) n_state = ST_SPAN;
                else n_state = ST_READ;
            end
            ST_DIV:   if (r_bit == '0) n_state = ST_SPAN;
            ST_SPAN:  n_state = ST_OUT;
            ST_OUT:   if (i_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_angle  <= i_ray_angle;
                r_axis   <= 1'b0;
                r_sn     <= SN_X;
                r_px     <= PW'({i_player_x, 6'd0});
                r_py     <= PW'({i_player_y, 6'd0});
                r_steps  <= '0;
                r_column <= i_column;
                r_hit    <= 1'b0;
            end
            ST_SINE: begin
                unique case (r_sn)
                    SN_X: begin
                        r_x  <= x_prod[42:11];
                        r_sn <= SN_X2;
                    end
                    SN_X2: begin
                        r_x2   <= sq_prod[61:30];
                        r_term <= r_x;
                        r_sum  <= $signed({2'b00, r_x});
                        r_iter <= '0;
                        r_sn   <= SN_MUL;
                    end
                    SN_MUL: begin
                        r_part <= tx_prod[61:30];
                        r_sn   <= SN_DIV;
                    end
                    SN_DIV: begin
                        r_term <= div_q;
                        if (r_iter[0]) r_sum <= r_sum + $signed({2'b00, div_q});
                        else r_sum <= r_sum - $signed({2'b00, div_q});
                        if (r_iter == 3'(rcwc_pkg::TAYLOR_TERMS - 1)) begin
                            r_sn <= SN_FIN;
                        end else begin
                            r_iter <= r_iter + 1'b1;
                            r_sn   <= SN_MUL;
                        end
                    end
                    SN_FIN: begin
                        if (r_axis) r_dx <= sin_v;
                        else r_dy <= sin_v;
                        r_axis <= 1'b1;
                        r_sn   <= SN_X;
                    end
                    default: r_sn <= SN_X;
                endcase
            end
            ST_TEST: begin
                if (wall) begin
                    r_hit  <= 1'b1;
                    r_quot <= NW'(rcwc_pkg::HEIGHT_NUM);
                    r_rem  <= '0;
                    r_bit  <= ($clog2(NW+1))'(NW - 1);
                end else if (r_steps < SW'(rcwc_pkg::MAX_STEPS)) begin
                    r_px    <= r_px + PW'(r_dx);
                    r_py    <= r_py + PW'(r_dy);
                    r_steps <= r_steps + 1'b1;
                end
            end
            ST_DIV: begin
                if (rem_sh >= (NW+1)'(r_steps)) begin
                    r_rem  <= NW'(rem_sh - (NW+1)'(r_steps));
                    r_quot <= {r_quot[NW-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[NW-1:0];
                    r_quot <= {r_quot[NW-2:0], 1'b0};
                end
                r_bit <= r_bit - 1'b1;
            end
            ST_SPAN: begin
                if (!r_hit) begin
                    r_start <= '0;
                    r_end   <= '0;
                end else if (r_steps == '0
                        || r_quot >= NW'(rcwc_pkg::SCREEN_HEIGHT)) begin
                    r_start <= '0;
                    r_end   <= 10'(rcwc_pkg::SCREEN_HEIGHT);
                end else begin
                    r_start <= 10'((NW'(rcwc_pkg::SCREEN_HEIGHT) - r_quot) >> 1);
                    r_end   <= 10'(((NW'(rcwc_pkg::SCREEN_HEIGHT) - r_quot) >> 1) + r_quot);
                end
            end
            default: ;
        endcase
    end

    assign o_valid      = (r_state == ST_OUT);
    assign o_out_column = r_column;
    assign o_span_start = r_start;
    assign o_span_end   = r_end;
    assign o_step_count = 12'(r_steps);
    assign o_hit        = r_hit;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !accept) else $error("accept while busy");
    a_steps_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TEST) |-> (r_steps <= SW'(rcwc_pkg::MAX_STEPS)))
        else $error("step count overrun");
    a_miss_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (r_steps == SW'(rcwc_pkg::MAX_STEPS)))
        else $error("miss before step limit");
endmodule
`default_nettype wire
